[rtl/core/dhcp_option_parser_macros.svh]
// Assertion macros for the DHCP option parser.
`ifndef DHCP_OPTION_PARSER_MACROS_SVH
`define DHCP_OPTION_PARSER_MACROS_SVH

// Condition in the same cycle.
`define DOP_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("dop check failed");

// Condition in the following cycle.
`define DOP_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("dop check failed");

`endif

[rtl/core/dop_pkg.sv]
`default_nettype none
package dop_pkg;

  localparam logic [7:0] CODE_PAD     = 8'd0;
  localparam logic [7:0] CODE_MASK    = 8'd1;
  localparam logic [7:0] CODE_ROUTER  = 8'd3;
  localparam logic [7:0] CODE_DNS     = 8'd6;
  localparam logic [7:0] CODE_MSGTYPE = 8'd53;
  localparam logic [7:0] CODE_SERVER  = 8'd54;
  localparam logic [7:0] CODE_END     = 8'd255;

  localparam int unsigned COUNT_W = 9;

  typedef struct packed {
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_primary;
    logic [31:0] dns_secondary;
    logic [31:0] server_identifier;
    logic        message_type_seen;
    logic        end_found;
  } dop_result_t;

endpackage
`default_nettype wire

[rtl/core/dop_in_if.sv]
`default_nettype none
interface dop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] option_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output option_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input option_byte, input first_byte, input last_byte,
                output ready);
endinterface
`default_nettype wire

[rtl/core/dop_out_if.sv]
`default_nettype none
interface dop_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] subnet_mask;
  logic [31:0] router_address;
  logic [31:0] dns_primary;
  logic [31:0] dns_secondary;
  logic [31:0] server_identifier;
  logic        message_type_seen;
  logic        end_found;

  modport source (output valid, output subnet_mask, output router_address,
                  output dns_primary, output dns_secondary, output server_identifier,
                  output message_type_seen, output end_found, input ready);
  modport sink (input valid, input subnet_mask, input router_address,
                input dns_primary, input dns_secondary, input server_identifier,
                input message_type_seen, input end_found, output ready);
endinterface
`default_nettype wire

[rtl/core/dop_walker.sv]
`default_nettype none
`include "dhcp_option_parser_macros.svh"
module dop_walker #(
  parameter int unsigned OPTION_AREA_BYTES = 308
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           option_byte,
  input  wire logic                 first_byte,
  input  wire logic                 last_byte,
  output      logic                 emit,
  output      dop_pkg::dop_result_t result
);
  import dop_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CODE = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // payload position saturates once past the second word
  localparam logic [3:0] POS_W1  = 4'd3;
  localparam logic [3:0] POS_W2  = 4'd7;
  localparam logic [3:0] POS_SAT = 4'd8;

  localparam logic [COUNT_W-1:0] AREA_LIMIT = COUNT_W'(OPTION_AREA_BYTES);

  logic [1:0]         phase, phase_next;
  logic [7:0]         code, code_next;
  logic [7:0]         rem, rem_next;
  logic [3:0]         pos, pos_next;
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [31:0]        word_shift, word_shift_next;
  logic [31:0]        cap_mask, cap_mask_next;
  logic [31:0]        cap_router, cap_router_next;
  logic [31:0]        cap_dns1, cap_dns1_next;
  logic [31:0]        cap_dns2, cap_dns2_next;
  logic [31:0]        cap_server, cap_server_next;
  logic               type_seen, type_seen_next;
  logic               active;
  logic               end_hit;
  logic [1:0]         phase_eff;

  always_comb begin
    active          = first_byte || (phase != PH_IDLE);
    phase_eff       = first_byte ? PH_CODE : phase;
    phase_next      = phase_eff;
    code_next       = code;
    rem_next        = rem;
    pos_next        = pos;
    word_shift_next = word_shift;
    type_seen_next  = type_seen;
    end_hit         = 1'b0;
    emit            = 1'b0;
    byte_count_next = (first_byte ? '0 : byte_count) + COUNT_W'(1);
    cap_mask_next   = first_byte ? '0 : cap_mask;
    cap_router_next = first_byte ? '0 : cap_router;
    cap_dns1_next   = first_byte ? '0 : cap_dns1;
    cap_dns2_next   = first_byte ? '0 : cap_dns2;
    cap_server_next = first_byte ? '0 : cap_server;

    unique case (phase_eff)
      PH_CODE: begin
        if (option_byte == CODE_END) begin
          end_hit    = 1'b1;
          phase_next = PH_IDLE;
        end else if (option_byte != CODE_PAD) begin
          code_next  = option_byte;
          phase_next = PH_LEN;
          if (option_byte == CODE_MSGTYPE) type_seen_next = 1'b1;
        end
      end
      PH_LEN: begin
        rem_next        = option_byte;
        pos_next        = '0;
        word_shift_next = '0;
        phase_next      = (option_byte != 8'd0) ? PH_DATA : PH_CODE;
      end
      PH_DATA: begin
        word_shift_next = {word_shift[23:0], option_byte};
        if (pos == POS_W1) begin
          case (code)
            CODE_MASK:   cap_mask_next   = word_shift_next;
            CODE_ROUTER: cap_router_next = word_shift_next;
            CODE_DNS:    cap_dns1_next   = word_shift_next;
            CODE_SERVER: cap_server_next = word_shift_next;
            default: ;
          endcase
        end else if (pos == POS_W2 && code == CODE_DNS) begin
          cap_dns2_next = word_shift_next;
        end
        if (pos != POS_SAT) pos_next = pos + 4'd1;
        rem_next = rem - 8'd1;
        if (rem_next == 8'd0) phase_next = PH_CODE;
      end
      default: ;
    endcase

    if (end_hit) begin
      emit = active;
    end else if (last_byte || byte_count_next >= AREA_LIMIT) begin
      emit       = active;
      phase_next = PH_IDLE;
    end

    result.subnet_mask       = cap_mask_next;
    result.router_address    = cap_router_next;
    result.dns_primary       = cap_dns1_next;
    result.dns_secondary     = cap_dns2_next;
    result.server_identifier = cap_server_next;
    result.message_type_seen = type_seen_next;
    result.end_found         = end_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      code       <= '0;
      rem        <= '0;
      pos        <= '0;
      byte_count <= '0;
      word_shift <= '0;
      cap_mask   <= '0;
      cap_router <= '0;
      cap_dns1   <= '0;
      cap_dns2   <= '0;
      cap_server <= '0;
      type_seen  <= 1'b0;
    end else if (step && active) begin
      phase      <= phase_next;
      code       <= code_next;
      rem        <= rem_next;
      pos        <= pos_next;
      byte_count <= byte_count_next;
      word_shift <= word_shift_next;
      cap_mask   <= cap_mask_next;
      cap_router <= cap_router_next;
      cap_dns1   <= cap_dns1_next;
      cap_dns2   <= cap_dns2_next;
      cap_server <= cap_server_next;
      type_seen  <= type_seen_next;
    end
  end

  `DOP_ASSERT_NEXT(a_first_starts_walk, step && first_byte && !emit, phase != PH_IDLE)
  `DOP_ASSERT_NOW(a_last_emits, step && last_byte && active, emit)
  `DOP_ASSERT_NOW(a_count_bounded, phase != PH_IDLE, byte_count < AREA_LIMIT)

endmodule
`default_nettype wire

[rtl/core/dhcp_option_parser.sv]
// DHCP option parser: walks the options area one byte per request.
// A result is valid in the cycle after the request byte that ends the walk is accepted.
// Throughput: 1 byte request per cycle while the output register is empty or being taken.
// The walk state updates in the accept cycle; the result register is the only stage.
// Reset (rst, synchronous): walker goes idle, counters, flags and captures clear,
// no result is pending.
`default_nettype none
module dhcp_option_parser #(
  parameter int unsigned OPTION_AREA_BYTES = 308
) (
  input wire logic clk,
  input wire logic rst,
  dop_in_if.sink   in_ch,
  dop_out_if.source out_ch
);
  import dop_pkg::*;

  logic        accept;
  logic        emit;
  dop_result_t result;
  dop_result_t out_data;
  logic        out_valid;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dop_walker #(
    .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
  ) u_walker (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .option_byte (in_ch.option_byte),
    .first_byte  (in_ch.first_byte),
    .last_byte   (in_ch.last_byte),
    .emit        (emit),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= result;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.subnet_mask       = out_data.subnet_mask;
  assign out_ch.router_address    = out_data.router_address;
  assign out_ch.dns_primary       = out_data.dns_primary;
  assign out_ch.dns_secondary     = out_data.dns_secondary;
  assign out_ch.server_identifier = out_data.server_identifier;
  assign out_ch.message_type_seen = out_data.message_type_seen;
  assign out_ch.end_found         = out_data.end_found;

endmodule
`default_nettype wire

[dv/tb_top.sv]
`default_nettype none
module tb_top;
  import dop_pkg::*;

  localparam int unsigned AREA_BYTES      = 308;
  localparam int unsigned RANDOM_REQUESTS = 1800;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned LONG_HOLD       = 80;
  localparam logic [7:0]  CODE_DOMAIN     = 8'd15;

  typedef enum logic [1:0] {WALK_IDLE, WALK_CODE, WALK_LEN, WALK_DATA} walk_phase_t;

  class option_scoreboard;
    walk_phase_t phase;
    logic [7:0]  code;
    logic [7:0]  remaining;
    logic [7:0]  position;
    logic [8:0]  count;
    logic [31:0] shift_word;
    dop_result_t walk;
    dop_result_t summaries[$];
    int unsigned failures;

    function new();
      phase      = WALK_IDLE;
      code       = '0;
      remaining  = '0;
      position   = '0;
      count      = '0;
      shift_word = '0;
      walk       = '0;
      failures   = 0;
    endfunction

    function void close_walk(bit at_end);
      dop_result_t r;
      r = walk;
      r.end_found = at_end;
      summaries.push_back(r);
      phase = WALK_IDLE;
    endfunction

    // Returns 1 when the request belongs to a walk, 0 when it is dropped while idle.
    function bit note_request(logic [7:0] b, bit first, bit last);
      if (first) begin
        walk.subnet_mask       = '0;
        walk.router_address    = '0;
        walk.dns_primary       = '0;
        walk.dns_secondary     = '0;
        walk.server_identifier = '0;
        count = '0;
        phase = WALK_CODE;
      end else if (phase == WALK_IDLE) begin
        return 1'b0;
      end
      count = count + 9'd1;
      case (phase)
        WALK_CODE: begin
          if (b == CODE_END) begin
            close_walk(1'b1);
            return 1'b1;
          end
          if (b != CODE_PAD) begin
            code = b;
            if (b == CODE_MSGTYPE) walk.message_type_seen = 1'b1;  // sticky until reset
            phase = WALK_LEN;
          end
        end
        WALK_LEN: begin
          remaining  = b;
          position   = '0;
          shift_word = '0;
          phase = (b != 8'd0) ? WALK_DATA : WALK_CODE;
        end
        default: begin
          shift_word = {shift_word[23:0], b};
          if (position == 8'd3) begin
            case (code)
              CODE_MASK:   walk.subnet_mask       = shift_word;
              CODE_ROUTER: walk.router_address    = shift_word;
              CODE_DNS:    walk.dns_primary       = shift_word;
              CODE_SERVER: walk.server_identifier = shift_word;
              default: ;
            endcase
          end else if (position == 8'd7 && code == CODE_DNS) begin
            walk.dns_secondary = shift_word;
          end
          if (position != 8'hFF) position = position + 8'd1;
          remaining = remaining - 8'd1;
          if (remaining == 8'd0) phase = WALK_CODE;
        end
      endcase
      if (last || count >= AREA_BYTES) close_walk(1'b0);
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_summary(dop_result_t got);
      dop_result_t want;
      if (summaries.size() == 0) begin
        $error("summary with none outstanding");
        failures++;
        return;
      end
      want = summaries.pop_front();
      compare_field("subnet_mask", want.subnet_mask, got.subnet_mask);
      compare_field("router_address", want.router_address, got.router_address);
      compare_field("dns_primary", want.dns_primary, got.dns_primary);
      compare_field("dns_secondary", want.dns_secondary, got.dns_secondary);
      compare_field("server_identifier", want.server_identifier, got.server_identifier);
      compare_field("message_type_seen", 32'(want.message_type_seen),
                    32'(got.message_type_seen));
      compare_field("end_found", 32'(want.end_found), 32'(got.end_found));
    endfunction
  endclass

  logic clk;
  logic rst;
  dop_in_if  in_ch();
  dop_out_if out_ch();

  option_scoreboard sb = new();
  logic [7:0]  area[$];
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  bit          rx_hold_req   = 1'b0;
  int unsigned rx_hold_left  = 0;
  int unsigned walk_requests = 0;
  int unsigned quiet_cycles  = 0;

  dhcp_option_parser #(.OPTION_AREA_BYTES(AREA_BYTES)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    dop_result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.subnet_mask       = out_ch.subnet_mask;
      got.router_address    = out_ch.router_address;
      got.dns_primary       = out_ch.dns_primary;
      got.dns_secondary     = out_ch.dns_secondary;
      got.server_identifier = out_ch.server_identifier;
      got.message_type_seen = out_ch.message_type_seen;
      got.end_found         = out_ch.end_found;
      sb.check_summary(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dhcp_option_parser: mismatch");
      $finish;
    end
  end

  task automatic send_request(logic [7:0] b, bit first, bit last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.option_byte <= b;
    in_ch.first_byte  <= first;
    in_ch.last_byte   <= last;
    do @(posedge clk); while (!in_ch.ready);
    void'(sb.note_request(b, first, last));
    walk_requests++;
  endtask

  task automatic send_area(int last_at);
    foreach (area[i]) send_request(area[i], i == 0, i == last_at);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.summaries.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_len(logic [7:0] usual);
    return ($urandom_range(3) != 0) ? usual : 8'($urandom_range(12));
  endfunction

  task automatic add_option(logic [7:0] c, logic [7:0] len);
    area.push_back(c);
    area.push_back(len);
    repeat (len) area.push_back(8'($urandom));
  endtask

  task automatic add_unknown_option(logic [7:0] len);
    logic [7:0] c;
    do c = 8'($urandom_range(2, 254));
    while (c == CODE_ROUTER || c == CODE_DNS || c == CODE_DOMAIN ||
           c == CODE_MSGTYPE || c == CODE_SERVER);
    add_option(c, len);
  endtask

  task automatic add_random_option();
    case ($urandom_range(9))
      0: repeat ($urandom_range(1, 3)) area.push_back(CODE_PAD);
      1: add_option(CODE_MASK, pick_len(8'd4));
      2: add_option(CODE_ROUTER, pick_len($urandom_range(1) ? 8'd4 : 8'd8));
      3: add_option(CODE_DNS, pick_len($urandom_range(1) ? 8'd4 : 8'd8));
      4: add_option(CODE_MSGTYPE, pick_len(8'd1));
      5: add_option(CODE_SERVER, pick_len(8'd4));
      6: add_option(CODE_DOMAIN, 8'($urandom_range(24)));
      7: add_unknown_option(8'($urandom_range(16)));
      default: add_option(CODE_DNS, pick_len(8'd12));
    endcase
  endtask

  initial begin : stimulus
    int pkt;
    int mode;
    int ending;
    int last_at;
    int cut;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.option_byte <= '0;
    in_ch.first_byte  <= 1'b0;
    in_ch.last_byte   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: dropped idle request, bare end, captures, short options, last on end
    send_request(8'hA5, 1'b0, 1'b1);
    area = '{CODE_END};
    send_area(-1);
    area = '{CODE_MASK, 8'd4, 8'hFF, 8'hFF, 8'hFF, 8'h00, CODE_PAD,
             CODE_DNS, 8'd5, 8'h08, 8'h08, 8'h08, 8'h08, 8'h01,
             CODE_MSGTYPE, 8'd1, 8'd5, CODE_END};
    send_area(-1);
    area = '{CODE_ROUTER};
    send_area(0);
    area = '{CODE_SERVER, 8'd2, 8'hC0, 8'hA8, CODE_ROUTER, 8'd0, CODE_END};
    send_area(6);

    walk_requests = 0;
    pkt = 0;
    while (walk_requests < RANDOM_REQUESTS) begin
      if (pkt % 10 == 0) begin
        wait_drained();
        case ((pkt / 10) % 4)
          0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1:       begin tx_idle_pct = 70; rx_stall_pct = 0;  end
          2:       begin tx_idle_pct = 0;  rx_stall_pct = 70; end
          default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
        endcase
      end
      if (pkt == 3) begin
        // receiver holds off while short areas keep coming
        rx_hold_req = 1'b1;
        area = '{CODE_END};
        repeat (8) send_area(-1);
      end
      area.delete();
      mode = $urandom_range(99);
      if (pkt == 20 || mode < 2) begin
        // runs into the area limit mid-option
        repeat ($urandom_range(1, 4)) add_random_option();
        while (area.size() <= AREA_BYTES + 4)
          add_option(CODE_DOMAIN, 8'($urandom_range(180, 255)));
        send_area(-1);
      end else if (mode < 12) begin
        repeat ($urandom_range(1, 20)) area.push_back(8'($urandom));
        send_area($urandom_range(1) ? area.size() - 1 : -1);
      end else begin
        repeat ($urandom_range(1, 6)) add_random_option();
        ending = $urandom_range(99);
        if (ending < 55) begin
          area.push_back(CODE_END);
          last_at = ($urandom_range(3) == 0) ? area.size() - 1 : -1;
          if ($urandom_range(2) == 0)
            repeat ($urandom_range(1, 3)) area.push_back(8'($urandom));
        end else if (ending < 75) begin
          last_at = area.size() - 1;
        end else if (ending < 90) begin
          last_at = $urandom_range(area.size() - 1);
        end else begin
          // abandoned walk; the next first request restarts it
          cut = $urandom_range(1, area.size());
          while (area.size() > cut) void'(area.pop_back());
          last_at = -1;
        end
        send_area(last_at);
      end
      pkt++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("dhcp_option_parser: match");
    end else begin
      $display("dhcp_option_parser: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
